@@ hw/rtl/elrr_pkg.sv @@
// Shared types and constants for the error latch round-robin reporter.
// Holds command codes, field widths and the controller/datapath link structs.
// No dependencies.
package elrr_pkg;

  localparam int unsigned ERROR_COUNT_DEF = 16;
  localparam int unsigned NO_ERROR_ID_DEF = 0;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ID_W       = 4;
  localparam int unsigned INTERVAL_W = 20;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(10000);
  localparam logic [INTERVAL_W-1:0] ELAPSED_MAX    = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_DETECT = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic set_flag;
    logic load_query;
    logic start_tick;
    logic scan_step;
    logic apply_report;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
    logic report_due;
  } dp_status_t;

endpackage

@@ hw/rtl/elrr_in_if.sv @@
// Request channel of the error latch reporter: valid/ready plus command fields.
// Depends on elrr_pkg.
interface elrr_in_if;
  logic                       valid;
  logic                       ready;
  logic [elrr_pkg::CMD_W-1:0] command;
  logic [elrr_pkg::ID_W-1:0]  fault_id;

  modport source (output valid, output command, output fault_id, input ready);
  modport sink   (input valid, input command, input fault_id, output ready);
endinterface

@@ hw/rtl/elrr_out_if.sv @@
// Result channel of the error latch reporter: valid/ready plus result fields.
// Depends on elrr_pkg.
interface elrr_out_if;
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic [elrr_pkg::ID_W-1:0] error_id_out;
  logic                      detected;

  modport source (output valid, output result_kind, output error_id_out, output detected,
                  input ready);
  modport sink   (input valid, input result_kind, input error_id_out, input detected,
                  output ready);
endinterface

@@ hw/rtl/error_latch_round_robin_reporter_core.sv @@
// Error latch round-robin reporter, top level.
// Instantiates elrr_ctrl and elrr_dp; uses elrr_pkg, elrr_in_if and elrr_out_if.
//
// Usage:
//   req_i carries one request: command (detect, tick, query) and fault_id.
//   rsp_o carries one result: result_kind (status or report), error_id_out,
//   detected. cfg_we_i/cfg_wdata_i write report_interval.
//   A detect request sets the sticky flag of its error number, unless that is
//   NO_ERROR_ID or out of range, and gives no result. A query answers with
//   the flag: its id is registered and the result is loaded once the output
//   register is free. A tick advances the saturating millisecond counter and
//   scans the flags one per cycle, then loads a report when one is due.
//   The flag scan uses the single flag read port; one request is worked
//   on at a time.
//   The result sits in an output register: a new request is taken while an
//   earlier result still waits. When the receiver stalls and a second result
//   is ready, the block holds it and takes no request until the register
//   frees up.
//   Reset clears all flags, the report position and the counter, and sets
//   report_interval to 10000.
module error_latch_round_robin_reporter_core #(
  parameter int unsigned ERROR_COUNT = elrr_pkg::ERROR_COUNT_DEF,
  parameter int unsigned NO_ERROR_ID = elrr_pkg::NO_ERROR_ID_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [elrr_pkg::INTERVAL_W-1:0] cfg_wdata_i,
  elrr_in_if.sink                         req_i,
  elrr_out_if.source                      rsp_o
);
  import elrr_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  elrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_cmd_i    (req_i.command),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (dp_cmd),
    .status_i    (dp_status)
  );

  elrr_dp #(
    .ERROR_COUNT (ERROR_COUNT),
    .NO_ERROR_ID (NO_ERROR_ID)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_id_i        (req_i.fault_id),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .result_kind_o  (rsp_o.result_kind),
    .error_id_out_o (rsp_o.error_id_out),
    .detected_o     (rsp_o.detected)
  );

endmodule

@@ hw/rtl/elrr_ctrl.sv @@
// Controller of the error latch reporter: one-hot state machine and result valid.
// Drives dp_cmd_t to the datapath and reads dp_status_t back. Depends on elrr_pkg.
module elrr_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [elrr_pkg::CMD_W-1:0] in_cmd_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output elrr_pkg::dp_cmd_t          cmd_o,
  input  elrr_pkg::dp_status_t       status_i
);
  import elrr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_cmd_i)
            CMD_DETECT: cmd_o.set_flag = 1'b1;
            CMD_TICK: begin
              cmd_o.start_tick = 1'b1;
              state_d          = ST_SCAN;
            end
            CMD_QUERY: begin
              cmd_o.load_query = 1'b1;
              state_d          = ST_EMIT;
            end
            default: ;  // unused code: drop
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status_i.report_due) begin
          cmd_o.apply_report = 1'b1;
          state_d            = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // hold until the output register can take the result
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/elrr_dp.sv @@
// Datapath of the error latch reporter: flags, interval, elapsed counter,
// serial flag scan, report position and the output register. Depends on elrr_pkg.
module elrr_dp #(
  parameter int unsigned ERROR_COUNT = elrr_pkg::ERROR_COUNT_DEF,
  parameter int unsigned NO_ERROR_ID = elrr_pkg::NO_ERROR_ID_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [elrr_pkg::INTERVAL_W-1:0] cfg_wdata_i,
  input  logic [elrr_pkg::ID_W-1:0]       in_id_i,
  input  elrr_pkg::dp_cmd_t               cmd_i,
  output elrr_pkg::dp_status_t            status_o,
  output logic                            result_kind_o,
  output logic [elrr_pkg::ID_W-1:0]       error_id_out_o,
  output logic                            detected_o
);
  import elrr_pkg::*;

  localparam int unsigned IDX_W = $clog2(ERROR_COUNT);
  localparam int unsigned CNT_W = $clog2(ERROR_COUNT + 1);
  localparam int unsigned AW    = (IDX_W > ID_W) ? IDX_W : ID_W;

  logic [ERROR_COUNT-1:0] flags_q, flags_d;
  logic [INTERVAL_W-1:0]  interval_q;
  logic [INTERVAL_W-1:0]  elapsed_q, elapsed_d;
  logic [IDX_W-1:0]       pos_q, pos_d;

  // scan working registers
  logic [IDX_W-1:0] scan_idx_q, scan_idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] first_q, first_d;
  logic [IDX_W-1:0] chosen_q, chosen_d;
  logic             found_q, found_d;

  // pending result
  logic             res_kind_q, res_kind_d;
  logic [ID_W-1:0]  res_id_q, res_id_d;

  logic             out_kind_q;
  logic [ID_W-1:0]  out_id_q;
  logic             out_det_q;

  logic [AW-1:0]    rd_addr;
  logic             rd_bit;
  logic [AW-1:0]    wr_addr;
  logic             wr_ok;
  logic [CNT_W-1:0] pos_ext;
  logic [CNT_W-1:0] pos_next;

  // single flag read port: scan index while scanning, else the pending id
  assign rd_addr = cmd_i.scan_step ? AW'(scan_idx_q) : AW'(res_id_q);
  assign rd_bit  = (32'(rd_addr) < ERROR_COUNT) ? flags_q[rd_addr[IDX_W-1:0]] : 1'b0;

  assign wr_addr = AW'(in_id_i);
  assign wr_ok   = (32'(in_id_i) != NO_ERROR_ID) && (32'(in_id_i) < ERROR_COUNT);

  assign pos_ext  = CNT_W'(pos_q);
  assign pos_next = pos_ext + CNT_W'(1);

  assign status_o.scan_last  = (32'(scan_idx_q) == ERROR_COUNT - 1);
  assign status_o.report_due = (cnt_q != '0) && (elapsed_q > interval_q);

  always_comb begin
    flags_d    = flags_q;
    elapsed_d  = elapsed_q;
    pos_d      = pos_q;
    scan_idx_d = scan_idx_q;
    cnt_d      = cnt_q;
    first_d    = first_q;
    chosen_d   = chosen_q;
    found_d    = found_q;
    res_kind_d = res_kind_q;
    res_id_d   = res_id_q;

    if (cmd_i.set_flag && wr_ok) begin
      flags_d[wr_addr[IDX_W-1:0]] = 1'b1;
    end

    if (cmd_i.load_query) begin
      res_kind_d = KIND_STATUS;
      res_id_d   = in_id_i;
    end

    if (cmd_i.start_tick) begin
      if (elapsed_q != ELAPSED_MAX) begin
        elapsed_d = elapsed_q + INTERVAL_W'(1);
      end
      scan_idx_d = '0;
      cnt_d      = '0;
      first_d    = '0;
      chosen_d   = '0;
      found_d    = 1'b0;
    end

    if (cmd_i.scan_step) begin
      if (rd_bit) begin
        if (cnt_q == '0) begin
          first_d = scan_idx_q;
        end
        if (cnt_q == pos_ext) begin
          chosen_d = scan_idx_q;
          found_d  = 1'b1;
        end
        cnt_d = cnt_q + CNT_W'(1);
      end
      scan_idx_d = scan_idx_q + IDX_W'(1);
    end

    if (cmd_i.apply_report) begin
      elapsed_d  = '0;
      res_kind_d = KIND_REPORT;
      if (cnt_q == CNT_W'(1) || !found_q) begin
        res_id_d = ID_W'(first_q);
      end else begin
        res_id_d = ID_W'(chosen_q);
      end
      // a single set flag leaves the position alone
      if (cnt_q != CNT_W'(1)) begin
        if (!found_q || pos_next >= cnt_q) begin
          pos_d = '0;
        end else begin
          pos_d = pos_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q    <= '0;
      elapsed_q  <= '0;
      pos_q      <= '0;
      interval_q <= INTERVAL_RESET;
    end else begin
      flags_q   <= flags_d;
      elapsed_q <= elapsed_d;
      pos_q     <= pos_d;
      if (cfg_we_i) begin
        interval_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    cnt_q      <= cnt_d;
    first_q    <= first_d;
    chosen_q   <= chosen_d;
    found_q    <= found_d;
    res_kind_q <= res_kind_d;
    res_id_q   <= res_id_d;
    if (cmd_i.load_out) begin
      out_kind_q <= res_kind_q;
      out_id_q   <= res_id_q;
      out_det_q  <= (res_kind_q == KIND_REPORT) ? 1'b0 : rd_bit;
    end
  end

  assign result_kind_o  = out_kind_q;
  assign error_id_out_o = out_id_q;
  assign detected_o     = out_det_q;

endmodule

@@ hw/rtl/elrr_checker.sv @@
// Port-level checks for the error latch round-robin reporter, bound to the top.
// Depends on elrr_pkg and error_latch_round_robin_reporter_core.
module elrr_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [elrr_pkg::CMD_W-1:0] in_cmd_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_kind_i,
  input logic [elrr_pkg::ID_W-1:0]  out_id_i,
  input logic                       out_det_i
);
  import elrr_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // a detect never produces a result
  a_detect_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_cmd_i == CMD_DETECT && !out_valid_i |=> !out_valid_i)
    else $error("result after detect request");

  // a query taken while the output register is empty is answered without a stall
  a_query_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_cmd_i == CMD_QUERY && !out_valid_i |=> ##1 out_valid_i)
    else $error("query not answered in time");

  // a tick starts the flag scan, so no request is taken next cycle
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_cmd_i == CMD_TICK |=> !in_ready_i)
    else $error("request taken during flag scan");

  a_report_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_REPORT |-> !out_det_i)
    else $error("report with detected set");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_kind_i) && $stable(out_id_i) && $stable(out_det_i))
    else $error("stalled result changed");

endmodule

bind error_latch_round_robin_reporter_core elrr_checker u_elrr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_cmd_i    (req_i.command),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_kind_i  (rsp_o.result_kind),
  .out_id_i    (rsp_o.error_id_out),
  .out_det_i   (rsp_o.detected)
);
